[sv/assert_macros.svh]
// Assertion helpers included by the mixer RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wvm_pkg.sv]
package wvm_pkg;

  localparam int VOICE_COUNT    = 8;
  localparam int BASE_TABLE_LEN = 200;

  // Table lengths follow the note frequencies in tenths of a hertz.
  localparam longint unsigned VOICE_LEN [8] = '{
    BASE_TABLE_LEN * 2616 / 2616,
    BASE_TABLE_LEN * 2616 / 2937,
    BASE_TABLE_LEN * 2616 / 3296,
    BASE_TABLE_LEN * 2616 / 3492,
    BASE_TABLE_LEN * 2616 / 3920,
    BASE_TABLE_LEN * 2616 / 4400,
    BASE_TABLE_LEN * 2616 / 4939,
    BASE_TABLE_LEN * 2616 / 5232
  };

  // Angle of entry k is 2*pi*k/len with pi as 3.14159, in units of 1e-5.
  localparam longint unsigned ANG_NUM      = 628318;
  localparam longint unsigned ANG_DEN_UNIT = 100000;

  localparam longint unsigned VOICE_DEN [8] = '{
    ANG_DEN_UNIT * VOICE_LEN[0], ANG_DEN_UNIT * VOICE_LEN[1],
    ANG_DEN_UNIT * VOICE_LEN[2], ANG_DEN_UNIT * VOICE_LEN[3],
    ANG_DEN_UNIT * VOICE_LEN[4], ANG_DEN_UNIT * VOICE_LEN[5],
    ANG_DEN_UNIT * VOICE_LEN[6], ANG_DEN_UNIT * VOICE_LEN[7]
  };

  localparam int PH_W      = $clog2(BASE_TABLE_LEN);
  localparam int VID_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int ADDR_W    = VID_W + PH_W;
  localparam int MEM_DEPTH = VOICE_COUNT << PH_W;

  localparam int MASK_W      = 8;
  localparam int SAMPLE_W    = 12;
  localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4094;
  localparam int SUM_W = $clog2(VOICE_COUNT * 4094 + 1);
  localparam int CNT_W = $clog2(VOICE_COUNT + 1);

  // Fixed-point sine generation: Q60 values in 64-bit words.
  localparam int Q_W    = 64;
  localparam int FRAC_W = 60;
  localparam int NUM_W  = $clog2(ANG_NUM * BASE_TABLE_LEN);
  localparam int DEN_W  = $clog2(ANG_DEN_UNIT * BASE_TABLE_LEN + 1);
  localparam int DIV_DW = NUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DIV_DW + 1);

  localparam logic [Q_W-1:0] Q60_ONE     = 64'h1000_0000_0000_0000;
  localparam logic [Q_W-1:0] Q60_PI      = 64'h3243_F6A8_885A_308D;
  localparam logic [Q_W-1:0] Q60_HALF_PI = Q60_PI >> 1;

  localparam logic [4:0] TAYLOR_FIRST = 5'd3;
  localparam logic [4:0] TAYLOR_LAST  = 5'd27;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

[sv/wvm_div.sv]
module wvm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wvm_pkg::div_ctl_t            ctl,
  input  logic [wvm_pkg::DIV_DW-1:0]   dividend,
  input  logic [wvm_pkg::DEN_W-1:0]    divisor,
  output wvm_pkg::unit_sts_t           sts,
  output logic [wvm_pkg::Q_W-1:0]      quotient
);
  import wvm_pkg::*;

  logic [DIV_DW-1:0] dvd_r, dvd_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    rem2;
  logic              ge;

  // Restoring division, one quotient bit per cycle; the dividend is loaded
  // with its most significant bit at the top of the shift register.
  always_comb begin
    rem2     = {rem_r, dvd_r[DIV_DW-1]};
    ge       = (rem2 >= {1'b0, den_r});
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      dvd_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = ctl.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      rem_nxt = ge ? DEN_W'(rem2 - {1'b0, den_r}) : rem2[DEN_W-1:0];
      quo_nxt = {quo_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

[sv/wvm_mul.sv]
module wvm_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [wvm_pkg::Q_W-1:0]  a,
  input  logic [wvm_pkg::Q_W-1:0]  b,
  output wvm_pkg::unit_sts_t       sts,
  output logic [wvm_pkg::Q_W-1:0]  prod
);
  import wvm_pkg::*;

  localparam int HW = Q_W / 2;

  logic [Q_W-1:0]   a_r, a_nxt;
  logic [Q_W-1:0]   b_r, b_nxt;
  logic [Q_W-1:0]   pp_r, pp_nxt;
  logic [1:0]       psel_r, psel_nxt;
  logic             pv_r, pv_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [2*Q_W-1:0] acc_r, acc_nxt;
  logic [HW-1:0]    opa, opb;
  logic [2*Q_W-1:0] pp_shift;

  // Four 32x32 partial products, one per cycle, each registered before it
  // is added into the 128-bit accumulator.
  always_comb begin
    opa = cnt_r[1] ? a_r[Q_W-1:HW] : a_r[HW-1:0];
    opb = cnt_r[0] ? b_r[Q_W-1:HW] : b_r[HW-1:0];
    case (psel_r)
      2'b00:   pp_shift = {{Q_W{1'b0}}, pp_r};
      2'b11:   pp_shift = {pp_r, {Q_W{1'b0}}};
      default: pp_shift = {{HW{1'b0}}, pp_r, {HW{1'b0}}};
    endcase

    a_nxt    = a_r;
    b_nxt    = b_r;
    pp_nxt   = pp_r;
    psel_nxt = psel_r;
    pv_nxt   = 1'b0;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (pv_r) begin
        acc_nxt = acc_r + pp_shift;
      end
      if (!cnt_r[2]) begin
        pp_nxt   = {{HW{1'b0}}, opa} * {{HW{1'b0}}, opb};
        psel_nxt = cnt_r[1:0];
        pv_nxt   = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pv_r   <= pv_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    pp_r   <= pp_nxt;
    psel_r <= psel_nxt;
    acc_r  <= acc_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  // Q60 product: bits 123..60 of the full product.
  assign prod     = acc_r[FRAC_W+Q_W-1:FRAC_W];

endmodule

[sv/wavetable_voice_mixer.sv]
// Channel  Direction  Handshake                Payload
// in       input      in_tvalid / in_tready    voice_mask (tdata bits 7..0)
// out      output     out_tvalid / out_tready  sample (tdata bits 11..0)
//
// After reset the shared divider and multiplier build the sine table in place,
// all 1141 entries, and no input transfer is taken until it is complete. Each
// sample then takes one table read per voice, then the shared divider at one
// quotient bit per cycle for the average; no new mask is taken until the sample
// has left S_OUT. A result waiting in the output register holds the next
// sample in S_OUT.
`include "assert_macros.svh"

module wavetable_voice_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wvm_pkg::MASK_W-1:0]         in_tdata,   // [7:0] voice_mask
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wvm_pkg::OUT_TDATA_W-1:0]    out_tdata   // [11:0] sample, zero above
);
  import wvm_pkg::*;

  typedef enum logic [17:0] {
    S_ANG    = 18'h00001,
    S_ANG_W  = 18'h00002,
    S_FOLD   = 18'h00004,
    S_SQ     = 18'h00008,
    S_SQ_W   = 18'h00010,
    S_TMUL   = 18'h00020,
    S_TMUL_W = 18'h00040,
    S_TDIV   = 18'h00080,
    S_TDIV_W = 18'h00100,
    S_SUM    = 18'h00200,
    S_CLAMP  = 18'h00400,
    S_WRITE  = 18'h00800,
    S_IDLE   = 18'h01000,
    S_RD     = 18'h02000,
    S_ACC    = 18'h04000,
    S_AVG    = 18'h08000,
    S_AVG_W  = 18'h10000,
    S_OUT    = 18'h20000
  } state_t;

  state_t            state_r, state_nxt;

  // Table build
  logic [VID_W-1:0]  fv_r, fv_nxt;
  logic [PH_W-1:0]   fk_r, fk_nxt;
  logic [Q_W-1:0]    x_r, x_nxt;
  logic [Q_W-1:0]    y2_r, y2_nxt;
  logic [Q_W-1:0]    s_r, s_nxt;
  logic [Q_W-1:0]    term_r, term_nxt;
  logic              neg_r, neg_nxt;
  logic [4:0]        n_r, n_nxt;

  // Sample path
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic [VID_W-1:0]    vi_r, vi_nxt;
  logic                rdv_r, rdv_nxt;
  logic                rden_r, rden_nxt;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PH_W-1:0]     phase_r [VOICE_COUNT];
  logic [PH_W-1:0]     phase_nxt [VOICE_COUNT];
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic [SAMPLE_W-1:0] tbl_mem [MEM_DEPTH];

  // Shared units
  div_ctl_t          div_ctl;
  logic [DIV_DW-1:0] div_dvd;
  logic [DEN_W-1:0]  div_den;
  unit_sts_t         div_sts;
  logic [Q_W-1:0]    div_quo;
  logic              mul_start;
  logic [Q_W-1:0]    mul_a, mul_b;
  unit_sts_t         mul_sts;
  logic [Q_W-1:0]    mul_prod;

  // Datapath helpers
  logic [NUM_W-1:0]  ang_num;
  logic [9:0]        tdiv;
  logic              fold_ge;
  logic [Q_W-1:0]    x_fold1, x_fold2;
  logic [Q_W-1:0]    s_clamp;
  logic [Q_W-9:0]    v_scaled;
  logic [Q_W+2:0]    v_2047;
  logic [14:0]       e_full;
  logic [SAMPLE_W-1:0] entry;
  logic              last_k, last_v;
  logic              out_free;

  wvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_den),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  wvm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  assign ang_num = NUM_W'(ANG_NUM) * NUM_W'(fk_r);
  assign tdiv    = ({5'd0, n_r} - 10'd1) * {5'd0, n_r};

  // Fold the angle into the first quadrant and keep the half-wave sign.
  assign fold_ge = (div_quo >= Q60_PI);
  assign x_fold1 = fold_ge ? div_quo - Q60_PI : div_quo;
  assign x_fold2 = (x_fold1 > Q60_HALF_PI) ?
                   ((x_fold1 <= Q60_PI) ? Q60_PI - x_fold1 : '0) : x_fold1;

  assign s_clamp  = (s_r > Q60_ONE) ? Q60_ONE : s_r;
  // x_r holds 1 +/- sin in Q60 by the time the entry is written.
  assign v_scaled = x_r[Q_W-1:8];
  assign v_2047   = {v_scaled, 11'd0} - {11'd0, v_scaled};
  assign e_full   = v_2047[Q_W+2:52];
  assign entry    = (e_full > 15'(SAMPLE_MAX)) ? SAMPLE_MAX : e_full[SAMPLE_W-1:0];

  assign last_k   = (fk_r == PH_W'(VOICE_LEN[fv_r] - 1));
  assign last_v   = (fv_r == VID_W'(VOICE_COUNT - 1));
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = '0;
    div_dvd       = '0;
    div_den       = '0;
    unique case (state_r)
      S_ANG: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(DIV_DW);
        div_dvd       = {ang_num, {FRAC_W{1'b0}}};
        div_den       = DEN_W'(VOICE_DEN[fv_r]);
      end
      S_TDIV: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(Q_W);
        div_dvd       = {mul_prod, {(DIV_DW-Q_W){1'b0}}};
        div_den       = DEN_W'(tdiv);
      end
      S_AVG: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEP_W'(SUM_W);
        div_dvd       = {sum_r, {(DIV_DW-SUM_W){1'b0}}};
        div_den       = (cnt_r == '0) ? DEN_W'(1) : DEN_W'(cnt_r);
      end
      default: begin
      end
    endcase
  end

  assign mul_start = (state_r == S_SQ) || (state_r == S_TMUL);
  assign mul_a     = (state_r == S_SQ) ? x_r : term_r;
  assign mul_b     = (state_r == S_SQ) ? x_r : y2_r;

  always_comb begin
    state_nxt     = state_r;
    fv_nxt        = fv_r;
    fk_nxt        = fk_r;
    x_nxt         = x_r;
    y2_nxt        = y2_r;
    s_nxt         = s_r;
    term_nxt      = term_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    mask_nxt      = mask_r;
    vi_nxt        = vi_r;
    rdv_nxt       = rdv_r;
    rden_nxt      = rden_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (rdv_r && rden_r) begin
      sum_nxt = sum_r + SUM_W'(rd_data_r);
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      S_ANG:    state_nxt = S_ANG_W;
      S_ANG_W: begin
        if (div_sts.done) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        x_nxt     = x_fold2;
        neg_nxt   = fold_ge;
        state_nxt = S_SQ;
      end
      S_SQ:     state_nxt = S_SQ_W;
      S_SQ_W: begin
        if (mul_sts.done) begin
          y2_nxt    = mul_prod;
          s_nxt     = x_r;
          term_nxt  = x_r;
          n_nxt     = TAYLOR_FIRST;
          state_nxt = S_TMUL;
        end
      end
      S_TMUL:   state_nxt = S_TMUL_W;
      S_TMUL_W: begin
        if (mul_sts.done) state_nxt = S_TDIV;
      end
      S_TDIV:   state_nxt = S_TDIV_W;
      S_TDIV_W: begin
        if (div_sts.done) state_nxt = S_SUM;
      end
      S_SUM: begin
        // Series terms alternate in sign; a negative partial sum floors at zero.
        term_nxt = div_quo;
        if (n_r[1]) begin
          s_nxt = (s_r >= div_quo) ? s_r - div_quo : '0;
        end else begin
          s_nxt = s_r + div_quo;
        end
        if (n_r == TAYLOR_LAST) begin
          state_nxt = S_CLAMP;
        end else begin
          n_nxt     = n_r + 5'd2;
          state_nxt = S_TMUL;
        end
      end
      S_CLAMP: begin
        x_nxt     = neg_r ? Q60_ONE - s_clamp : Q60_ONE + s_clamp;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (last_k) begin
          fk_nxt = '0;
          if (last_v) begin
            state_nxt = S_IDLE;
          end else begin
            fv_nxt    = fv_r + VID_W'(1);
            state_nxt = S_ANG;
          end
        end else begin
          fk_nxt    = fk_r + PH_W'(1);
          state_nxt = S_ANG;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          mask_nxt  = in_tdata;
          vi_nxt    = '0;
          rdv_nxt   = 1'b0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rdv_nxt  = 1'b1;
        rden_nxt = mask_r[vi_r];
        if (vi_r == VID_W'(VOICE_COUNT - 1)) begin
          state_nxt = S_ACC;
        end else begin
          vi_nxt = vi_r + VID_W'(1);
        end
      end
      S_ACC: begin
        rdv_nxt   = 1'b0;
        state_nxt = S_AVG;
      end
      S_AVG: begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
          phase_nxt[v] = (phase_r[v] == PH_W'(VOICE_LEN[v] - 1)) ?
                         '0 : phase_r[v] + PH_W'(1);
        end
        state_nxt = S_AVG_W;
      end
      S_AVG_W: begin
        if (div_sts.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_data_nxt  = div_quo[SAMPLE_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ANG;
      fv_r        <= '0;
      fk_r        <= '0;
      vi_r        <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        phase_r[v] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      fv_r        <= fv_nxt;
      fk_r        <= fk_nxt;
      vi_r        <= vi_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        phase_r[v] <= phase_nxt[v];
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y2_r       <= y2_nxt;
    s_r        <= s_nxt;
    term_r     <= term_nxt;
    neg_r      <= neg_nxt;
    n_r        <= n_nxt;
    mask_r     <= mask_nxt;
    rden_r     <= rden_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sine table: written during the build, one registered read per cycle in S_RD after.
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      tbl_mem[{fv_r, fk_r}] <= entry;
    end
    if (state_r == S_RD) begin
      rd_data_r <= tbl_mem[{vi_r, phase_r[vi_r]}];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SAMPLE_W){1'b0}}, out_data_r};

  `WVM_ASSERT_IMP(a_div_start_free, div_ctl.start, !div_sts.busy, "divider restarted while busy")
  `WVM_ASSERT_IMP(a_mul_start_free, mul_start, !mul_sts.busy, "multiplier restarted while busy")
  `WVM_ASSERT_NXT(a_accept_reads, in_tvalid && in_tready, state_r == S_RD, "transfer not followed by reads")
  `WVM_ASSERT_IMP(a_phase0_range, 1'b1, phase_r[0] <= PH_W'(VOICE_LEN[0] - 1), "voice 0 phase out of range")

endmodule

[sim/mixer_checker.sv]
`timescale 1ns / 100ps

module mixer_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [wvm_pkg::MASK_W-1:0]      in_tdata,   // [7:0] voice_mask
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [wvm_pkg::OUT_TDATA_W-1:0] out_tdata,  // [11:0] sample, zero above
  output int unsigned                     fail_count,
  output int unsigned                     pending
);
  import wvm_pkg::*;

  // Note frequencies in tenths of a hertz; they set each voice's table length.
  localparam int unsigned NOTE_TENTHS [8] = '{2616, 2937, 3296, 3492, 3920, 4400, 4939, 5232};

  logic [SAMPLE_W-1:0] sine_tab [8][BASE_TABLE_LEN];
  int unsigned         tab_len  [8];
  logic [7:0]          phase    [8];
  logic [SAMPLE_W-1:0] expected_samples [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Product of two Q60 values, truncated back to Q60.
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned k, input int unsigned len);
    logic [127:0] num;
    logic [127:0] den;
    logic [63:0]  x;
    logic [63:0]  y2;
    logic [63:0]  s;
    logic [63:0]  term;
    logic [63:0]  v;
    logic [63:0]  e;
    logic         neg;
    int           n;
    num = (128'(k) * 128'd628318) << 60;
    den = 128'(len) * 128'd100000;
    x   = 64'(num / den);
    neg = 1'b0;
    // Fold the angle into the first quadrant and keep the sign of the sine.
    if (x >= Q60_PI) begin
      x   = x - Q60_PI;
      neg = 1'b1;
    end
    if (x > (Q60_PI >> 1)) x = (x <= Q60_PI) ? Q60_PI - x : 64'd0;
    y2   = q60_mul(x, x);
    s    = x;
    term = x;
    for (n = 3; n <= 27; n += 2) begin
      term = q60_mul(term, y2) / 64'((n - 1) * n);
      if ((((n - 1) / 2) % 2) == 1) s = (s >= term) ? s - term : 64'd0;
      else s = s + term;
    end
    if (s > Q60_ONE) s = Q60_ONE;
    v = neg ? Q60_ONE - s : Q60_ONE + s;
    e = ((v >> 8) * 64'd2047) >> 52;
    if (e > 64'd4094) e = 64'd4094;
    return e[SAMPLE_W-1:0];
  endfunction

  // Average of the enabled voices at their current phases.
  function automatic logic [SAMPLE_W-1:0] mix_sample(input logic [MASK_W-1:0] mask);
    int unsigned total;
    int unsigned voices;
    total  = 0;
    voices = 0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (mask[v]) begin
        total  += sine_tab[v][phase[v]];
        voices += 1;
      end
    end
    if (voices == 0) voices = 1;
    return SAMPLE_W'(total / voices);
  endfunction

  initial begin
    int unsigned len;
    for (int v = 0; v < 8; v++) begin
      tab_len[v] = 1;
      phase[v]   = '0;
    end
    for (int v = 0; v < VOICE_COUNT; v++) begin
      len = BASE_TABLE_LEN * 2616 / NOTE_TENTHS[v];
      if (len < 1) len = 1;
      if (len > BASE_TABLE_LEN) len = BASE_TABLE_LEN;
      tab_len[v] = len;
      for (int k = 0; k < len; k++) sine_tab[v][k] = sine_entry(k, len);
    end
  end

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      for (int v = 0; v < 8; v++) phase[v] = '0;
    end else begin
      // The result of a transfer taken at this edge cannot leave at the same edge,
      // so the output side is matched first.
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $error("sample: expected none, actual %0d", out_tdata[SAMPLE_W-1:0]);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== want) begin
            $error("sample: expected %0d, actual %0d", want, out_tdata[SAMPLE_W-1:0]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_samples.push_back(mix_sample(in_tdata));
        // Every voice advances, enabled or not.
        for (int v = 0; v < 8; v++)
          phase[v] = (32'(phase[v]) + 1 >= tab_len[v]) ? 8'd0 : phase[v] + 8'd1;
      end
    end
    pending <= expected_samples.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import wvm_pkg::*;

  // The cycle limit also has to cover the table build after reset.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned RANDOM_TICKS = 1080;
  localparam int unsigned DRAIN_CYCLES = 40;

  localparam logic [MASK_W-1:0] DIRECTED_MASKS [19] = '{
    8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'hFE, 8'h7F, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h03, 8'hC0, 8'h81
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [MASK_W-1:0]      in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   steady     = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int unsigned            fail_count;
  int unsigned            pending;
  int unsigned            cycles = 0;

  always #5 clk = ~clk;

  wavetable_voice_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mixer_checker mixer_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 33);
  end

  task automatic send_mask(input logic [MASK_W-1:0] mask);
    if (!steady) begin
      while ($urandom_range(0, 99) < 33) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= mask;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Holds the input side idle until every result has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly random masks, with extra weight on silence, all voices and solo voices.
  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 9)) inside
      0:       return 8'h00;
      1:       return 8'hFF;
      [2:4]:   return 8'd1 << $urandom_range(0, 7);
      default: return MASK_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_MASKS[i]) send_mask(DIRECTED_MASKS[i]);
    for (int i = 0; i < RANDOM_TICKS; i++) begin
      steady <= (i >= 500 && i < 700);
      if (i == 300) drain_results();
      send_mask(random_mask());
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
